/* design/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command codes, pin levels and the transaction types for both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // Operation codes of an input transaction; the command codes share them.
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ_ACK  = 3'd4;
  localparam logic [2:0] OP_READ_NACK = 3'd5;

  // Active command codes; idle means no sequence runs.
  localparam logic [2:0] CMD_IDLE      = OP_TICK;
  localparam logic [2:0] CMD_START     = OP_START;
  localparam logic [2:0] CMD_STOP      = OP_STOP;
  localparam logic [2:0] CMD_WRITE     = OP_WRITE;
  localparam logic [2:0] CMD_READ_ACK  = OP_READ_ACK;
  localparam logic [2:0] CMD_READ_NACK = OP_READ_NACK;

  // Phase length after reset.
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;

  // Levels on the bus pins.
  typedef struct packed {
    logic en;
    logic sda;
    logic scl;
  } pins_t;

  // One input transaction.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_en;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
    logic       cmd_rejected;
  } out_t;

endpackage

`default_nettype wire

/* design/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine
// Runs START, STOP, write byte and read byte waveforms of an I2C master, one
// tick per input transaction, with a configurable length of each delay phase.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   -------   -------------------   ----------------------------------------
//   input     in_valid / in_ready   in_data   (op, tx_byte, sda_sample)
//   output    out_valid / out_ready out_data  (pins, status, rx_byte, flags)
//   config    cfg_we                cfg_wdata (phase_ticks)
//
// Every input transaction yields exactly one result. An accepted input is held
// in the input register and moves on into the result register when the engine
// steps. One transaction is taken per cycle while the output is not stalled;
// the phase and tick counters update in a single pass of logic between the two
// registers. A stall on the output holds both registers; the input keeps taking
// transactions as long as the input register can drain.
// Reset (synchronous, active high) sets the engine idle, pins low and
// released, and the phase length to 100 ticks.
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire i2cm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output i2cm_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_wdata
);

  import i2cm_pkg::*;

  // Pin levels on entry to a phase of the given command.
  function automatic pins_t enter_pins(input logic [2:0] cmd, input logic [3:0] p,
                                       input logic b, input pins_t cur);
    pins_t r;
    r = cur;
    unique case (cmd)
      CMD_START: begin
        if (p == 4'd0) r = '{en: 1'b1, sda: 1'b1, scl: 1'b1};
        else if (p == 4'd1) r = '{en: 1'b1, sda: 1'b0, scl: 1'b1};
        else r = '{en: 1'b1, sda: 1'b0, scl: 1'b0};
      end
      CMD_STOP: begin
        if (p == 4'd0) r = '{en: cur.en, sda: cur.sda, scl: 1'b0};
        else if (p == 4'd1) r = '{en: 1'b1, sda: 1'b0, scl: 1'b0};
        else if (p == 4'd2) r = '{en: 1'b1, sda: 1'b0, scl: 1'b1};
        else r = '{en: 1'b1, sda: 1'b1, scl: 1'b1};
      end
      CMD_WRITE: begin
        if (p == 4'd0) r = '{en: 1'b1, sda: b, scl: 1'b0};
        else if (p == 4'd1) r = '{en: 1'b1, sda: b, scl: 1'b1};
        else if (p == 4'd2) r = '{en: 1'b1, sda: cur.sda, scl: 1'b0};
        else if (p == 4'd3) r = '{en: 1'b1, sda: 1'b1, scl: 1'b0};
        else r = '{en: 1'b0, sda: 1'b1, scl: 1'b1};
      end
      CMD_READ_ACK: begin
        if (p == 4'd0) r = '{en: 1'b0, sda: 1'b1, scl: 1'b1};
        else if (p == 4'd1) r = '{en: 1'b0, sda: 1'b1, scl: 1'b0};
        else if (p == 4'd3) r = '{en: 1'b1, sda: 1'b0, scl: 1'b1};
        else r = '{en: 1'b1, sda: 1'b0, scl: 1'b0};
      end
      default: begin
        if (p == 4'd0) r = '{en: 1'b0, sda: 1'b1, scl: 1'b1};
        else if (p == 4'd1) r = '{en: 1'b0, sda: 1'b1, scl: 1'b0};
        else if (p == 4'd4) r = '{en: 1'b1, sda: 1'b1, scl: 1'b1};
        else r = '{en: 1'b1, sda: 1'b1, scl: 1'b0};
      end
    endcase
    return r;
  endfunction

  // Configuration and engine state.
  logic [15:0] phase_ticks;
  logic [2:0]  active_cmd;
  logic [3:0]  phase_index;
  logic [3:0]  bit_count;
  logic [15:0] tick_count;
  logic [7:0]  shift_reg;
  logic [7:0]  received_byte;
  pins_t       pins;
  logic        nack_flag;

  logic [2:0]  active_cmd_next;
  logic [3:0]  phase_index_next;
  logic [3:0]  bit_count_next;
  logic [15:0] tick_count_next;
  logic [7:0]  shift_reg_next;
  logic [7:0]  received_byte_next;
  pins_t       pins_next;
  logic        nack_flag_next;

  // Input register and flow control.
  logic        s1_valid;
  in_t         s1_data;
  logic        advance;
  logic        fire;

  // Step logic intermediates.
  logic        is_cmd;
  logic        rejected;
  logic        done;
  logic        finish;
  logic [15:0] tick_inc;
  logic [15:0] limit;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire     = s1_valid && advance;
  assign limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign tick_inc = tick_count + 16'd1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // One tick of the engine: accept a command while idle, otherwise count the
  // tick and run the end of the phase when its length is reached.
  always_comb begin
    active_cmd_next    = active_cmd;
    phase_index_next   = phase_index;
    bit_count_next     = bit_count;
    tick_count_next    = tick_count;
    shift_reg_next     = shift_reg;
    received_byte_next = received_byte;
    pins_next          = pins;
    nack_flag_next     = nack_flag;
    rejected           = 1'b0;
    done               = 1'b0;
    finish             = 1'b0;
    is_cmd = (s1_data.op >= OP_START) && (s1_data.op <= OP_READ_NACK);

    if (active_cmd == CMD_IDLE) begin
      if (is_cmd) begin
        active_cmd_next  = s1_data.op;
        phase_index_next = 4'd0;
        bit_count_next   = 4'd0;
        tick_count_next  = 16'd0;
        shift_reg_next   = (s1_data.op == OP_WRITE) ? s1_data.tx_byte : 8'd0;
        pins_next = enter_pins(s1_data.op, 4'd0, shift_reg_next[7], pins);
      end
    end else begin
      rejected        = is_cmd;
      tick_count_next = tick_inc;
      if (tick_inc >= limit) begin
        tick_count_next = 16'd0;
        unique case (active_cmd)
          CMD_START: begin
            if (phase_index >= 4'd2) finish = 1'b1;
            else phase_index_next = phase_index + 4'd1;
          end
          CMD_STOP: begin
            if (phase_index >= 4'd3) finish = 1'b1;
            else phase_index_next = phase_index + 4'd1;
          end
          CMD_WRITE: begin
            if (phase_index == 4'd1) begin
              shift_reg_next   = {shift_reg[6:0], 1'b0};
              bit_count_next   = bit_count + 4'd1;
              phase_index_next = (bit_count_next < 4'd8) ? 4'd0 : 4'd2;
            end else if (phase_index >= 4'd4) begin
              // SCL falls and the acknowledge is taken from SDA.
              pins_next      = '{en: 1'b0, sda: 1'b1, scl: 1'b0};
              nack_flag_next = s1_data.sda_sample;
              finish         = 1'b1;
            end else begin
              phase_index_next = phase_index + 4'd1;
            end
          end
          default: begin
            if (phase_index == 4'd0) begin
              shift_reg_next   = {shift_reg[6:0], s1_data.sda_sample};
              phase_index_next = 4'd1;
            end else if (phase_index == 4'd1) begin
              bit_count_next = bit_count + 4'd1;
              if (bit_count_next < 4'd8) begin
                phase_index_next = 4'd0;
              end else begin
                received_byte_next = shift_reg;
                phase_index_next   = 4'd2;
              end
            end else if (phase_index >= ((active_cmd == CMD_READ_ACK) ? 4'd4 : 4'd5)) begin
              finish = 1'b1;
            end else begin
              phase_index_next = phase_index + 4'd1;
            end
          end
        endcase

        if (finish) begin
          active_cmd_next  = CMD_IDLE;
          phase_index_next = 4'd0;
          bit_count_next   = 4'd0;
          done             = 1'b1;
        end else begin
          pins_next = enter_pins(active_cmd, phase_index_next, shift_reg_next[7], pins);
        end
      end
    end
  end

  // Engine state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_cmd    <= CMD_IDLE;
      phase_index   <= 4'd0;
      bit_count     <= 4'd0;
      tick_count    <= 16'd0;
      shift_reg     <= 8'd0;
      received_byte <= 8'd0;
      pins          <= '0;
      nack_flag     <= 1'b0;
    end else if (fire) begin
      active_cmd    <= active_cmd_next;
      phase_index   <= phase_index_next;
      bit_count     <= bit_count_next;
      tick_count    <= tick_count_next;
      shift_reg     <= shift_reg_next;
      received_byte <= received_byte_next;
      pins          <= pins_next;
      nack_flag     <= nack_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.scl_level    <= pins_next.scl;
      out_data.sda_level    <= pins_next.sda;
      out_data.sda_drive_en <= pins_next.en;
      out_data.busy_res     <= (active_cmd_next != CMD_IDLE);
      out_data.done_res     <= done;
      out_data.rx_byte      <= received_byte_next;
      out_data.ack_error    <= nack_flag_next;
      out_data.cmd_rejected <= rejected;
    end
  end

`ifndef SYNTH
  // A transaction that leaves the input register always lands in the result register.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted transaction produced no result");

  // Counters return to zero whenever the engine is idle.
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    (active_cmd == CMD_IDLE) |-> (phase_index == 4'd0 && bit_count == 4'd0))
    else $error("counters not cleared while idle");

  // No more than eight bits are ever counted.
  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'd8)
    else $error("bit count beyond eight");

  // The longest waveform has six phases.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_index <= 4'd5)
    else $error("phase index out of range");

  // The acknowledge flag changes only at the end of a write.
  a_nack_on_write: assert property (@(posedge clk) disable iff (rst)
    !$stable(nack_flag) |-> ($past(active_cmd) == CMD_WRITE && !$past(rst)))
    else $error("acknowledge flag changed outside a write");
`endif

endmodule

`default_nettype wire
